// ===== sv/asc_pkg.sv =====
package asc_pkg;

  // Field and datapath widths
  localparam int unsigned RAW_W      = 8;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned ALERT_BIT  = 6;
  localparam int unsigned GS_W       = 8;
  localparam int unsigned SCALE_W    = 14;  // count * gravity step
  localparam int unsigned AXIS_W     = 16;  // after remap / swap
  localparam int unsigned SUM_W      = 20;  // running sums and quotients
  localparam int unsigned MAG_W      = 19;  // magnitude of a sum
  localparam int unsigned DZ_W       = 21;  // dead-zone result before truncation
  localparam int unsigned PULL_W     = 10;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DROP_W     = 2;
  localparam int unsigned MAP_W      = 18;

  // Reciprocal divide: exact floor for magnitudes below 2^19 and divisors up to 16
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_W     = 28;

  localparam int signed   DEAD_ZONE  = 100;
  localparam int unsigned PULL_STEPS = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY_STEP    = 2'd0,
    CFG_REMAP_ENABLE    = 2'd1,
    CFG_ORIENTATION_MAP = 2'd2,
    CFG_SWAP_XY         = 2'd3
  } cfg_idx_e;

  localparam logic [GS_W-1:0]  GRAVITY_STEP_RST    = 8'd47;
  localparam logic [MAP_W-1:0] ORIENTATION_MAP_RST = 18'd65793;

  // Orientation matrix entry codes; the unused code acts as zero
  localparam logic [1:0] MAP_PLUS  = 2'b01;
  localparam logic [1:0] MAP_MINUS = 2'b11;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
    logic [RAW_W-1:0] z_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
  } out_item_t;

endpackage

// ===== sv/accel_sample_conditioner.sv =====
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-----------------------------------
// input    | in_valid_i / in_stall_o      | in_item_i  (kind, x/y/z raw bytes)
// output   | out_valid_o / out_stall_i    | out_item_o (x/y/z reported values)
// config   | cfg_we_i, cfg_idx_i          | cfg_wdata_i (no read-back)
//
// One item per cycle sustained while the input is not stalled; after its
// last sample is taken, a report passes the input, scale, accumulate,
// divide and dead zone/output registers in that order.
// Reset (async, active low) empties the pipe, clears sums, count and drop
// counter, and loads the register defaults. No clearing pass.
// The pipe fills bubbles under output stall; the input stalls only when
// every stage holds an item and the output register is stalled.
module accel_sample_conditioner
  import asc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_REPORT = 1,
  parameter int unsigned DROP_REPORTS       = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GS_W-1:0]  gravity_step_q;
  logic             remap_enable_q;
  logic [MAP_W-1:0] orientation_map_q;
  logic             swap_xy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_step_q    <= GRAVITY_STEP_RST;
      remap_enable_q    <= 1'b0;
      orientation_map_q <= ORIENTATION_MAP_RST;
      swap_xy_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY_STEP:    gravity_step_q    <= cfg_wdata_i[GS_W-1:0];
        CFG_REMAP_ENABLE:    remap_enable_q    <= cfg_wdata_i[0];
        CFG_ORIENTATION_MAP: orientation_map_q <= cfg_wdata_i[MAP_W-1:0];
        CFG_SWAP_XY:         swap_xy_q         <= cfg_wdata_i[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline load enables: a stage loads when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic ld1, ld2, ld3, ld4, ld_o;

  assign ld_o = !out_v_q || !out_stall_i;
  assign ld4  = !s4_v_q || ld_o;
  assign ld3  = !s3_v_q || ld4;
  assign ld2  = !s2_v_q || ld3;
  assign ld1  = !s1_v_q || ld2;

  assign in_stall_o = !ld1;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  in_item_t s1_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: alert filter and per-axis scaling
  // ---------------------------------------------------------------------------
  logic                      alert_x, alert_y, alert_z, alert_any;
  logic signed [SCALE_W-1:0] sc_x, sc_y, sc_z;
  logic                      s2_restart_q;
  logic signed [SCALE_W-1:0] s2_x_q, s2_y_q, s2_z_q;

  asc_axis_scale u_scale_x (
    .raw_i(s1_q.x_raw), .gravity_step_i(gravity_step_q), .alert_o(alert_x), .scaled_o(sc_x)
  );
  asc_axis_scale u_scale_y (
    .raw_i(s1_q.y_raw), .gravity_step_i(gravity_step_q), .alert_o(alert_y), .scaled_o(sc_y)
  );
  asc_axis_scale u_scale_z (
    .raw_i(s1_q.z_raw), .gravity_step_i(gravity_step_q), .alert_o(alert_z), .scaled_o(sc_z)
  );

  assign alert_any = alert_x || alert_y || alert_z;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_restart_q <= s1_q.kind;
      s2_x_q       <= sc_x;
      s2_y_q       <= sc_y;
      s2_z_q       <= sc_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: remap, swap and accumulate; a completed report is latched
  // ---------------------------------------------------------------------------
  function automatic logic signed [AXIS_W-1:0] map_term(input logic [1:0] code,
                                                         input logic signed [AXIS_W-1:0] a);
    logic signed [AXIS_W-1:0] r;
    case (code)
      MAP_PLUS:  r = a;
      MAP_MINUS: r = -a;
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic signed [AXIS_W-1:0] ax [3];
  logic signed [AXIS_W-1:0] mx [3];
  logic signed [AXIS_W-1:0] rx, ry, rz;
  logic signed [AXIS_W-1:0] vx, vy, vz;

  assign ax[0] = AXIS_W'(s2_x_q);
  assign ax[1] = AXIS_W'(s2_y_q);
  assign ax[2] = AXIS_W'(s2_z_q);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mx[r] = map_term(orientation_map_q[2*(3*r)   +: 2], ax[0])
            + map_term(orientation_map_q[2*(3*r+1) +: 2], ax[1])
            + map_term(orientation_map_q[2*(3*r+2) +: 2], ax[2]);
    end
  end

  assign rx = remap_enable_q ? mx[0] : ax[0];
  assign ry = remap_enable_q ? mx[1] : ax[1];
  assign rz = remap_enable_q ? mx[2] : ax[2];

  // swap: new x = y, new y = -x
  assign vx = swap_xy_q ? ry  : rx;
  assign vy = swap_xy_q ? -rx : ry;
  assign vz = rz;

  logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic signed [SUM_W-1:0] tot_x, tot_y, tot_z;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W:0]          cnt_next;
  logic                    report;
  logic                    acc_en;

  assign tot_x    = sum_x_q + SUM_W'(vx);
  assign tot_y    = sum_y_q + SUM_W'(vy);
  assign tot_z    = sum_z_q + SUM_W'(vz);
  assign cnt_next = {1'b0, cnt_q} + 1'b1;
  assign report   = cnt_next >= (CNT_W+1)'(SAMPLES_PER_REPORT);
  assign acc_en   = s2_v_q && !s2_restart_q && ld3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      cnt_q   <= '0;
    end else if (acc_en) begin
      if (report) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        cnt_q   <= '0;
      end else begin
        sum_x_q <= tot_x;
        sum_y_q <= tot_y;
        sum_z_q <= tot_z;
        cnt_q   <= cnt_next[CNT_W-1:0];
      end
    end
  end

  logic                    s3_restart_q;
  logic signed [SUM_W-1:0] s3_x_q, s3_y_q, s3_z_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_restart_q <= s2_restart_q;
      s3_x_q       <= tot_x;
      s3_y_q       <= tot_y;
      s3_z_q       <= tot_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: average (divide toward zero by the report length)
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] qx, qy, qz;
  logic                    s4_restart_q;
  logic signed [SUM_W-1:0] s4_x_q, s4_y_q, s4_z_q;

  asc_avg_div #(.SAMPLES_PER_REPORT(SAMPLES_PER_REPORT)) u_div_x (.sum_i(s3_x_q), .quot_o(qx));
  asc_avg_div #(.SAMPLES_PER_REPORT(SAMPLES_PER_REPORT)) u_div_y (.sum_i(s3_y_q), .quot_o(qy));
  asc_avg_div #(.SAMPLES_PER_REPORT(SAMPLES_PER_REPORT)) u_div_z (.sum_i(s3_z_q), .quot_o(qz));

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s4_restart_q <= s3_restart_q;
      s4_x_q       <= qx;
      s4_y_q       <= qy;
      s4_z_q       <= qz;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: dead zone on x/y, drop counter, output register
  // ---------------------------------------------------------------------------
  function automatic logic signed [DZ_W-1:0] dead_zone(input logic signed [SUM_W-1:0] v,
                                                        input logic [PULL_W-1:0] pull);
    logic signed [DZ_W-1:0] ve;
    logic signed [DZ_W-1:0] pe;
    logic signed [DZ_W-1:0] r;
    ve = DZ_W'(v);
    pe = $signed({{(DZ_W-PULL_W){1'b0}}, pull});
    if (ve > DZ_W'(DEAD_ZONE)) begin
      r = ve - pe;
    end else if (ve < -DZ_W'(DEAD_ZONE)) begin
      r = ve + pe;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  logic [PULL_W-1:0]      pull;
  logic signed [DZ_W-1:0] dx, dy;
  logic [DROP_W-1:0]      drop_q;
  logic                   all_zero;
  logic                   suppress;
  out_item_t              out_q;

  assign pull     = PULL_W'(PULL_STEPS) * PULL_W'(gravity_step_q);
  assign dx       = dead_zone(s4_x_q, pull);
  assign dy       = dead_zone(s4_y_q, pull);
  assign all_zero = (dx == '0) && (dy == '0) && (s4_z_q == '0);
  // an armed report that reads all zero is swallowed
  assign suppress = (drop_q != '0) && all_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= '0;
    end else if (ld_o && s4_v_q) begin
      if (s4_restart_q) begin
        drop_q <= DROP_W'(DROP_REPORTS);
      end else if (drop_q != '0) begin
        drop_q <= drop_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_o) begin
      out_q.x_out <= dx[15:0];
      out_q.y_out <= dy[15:0];
      out_q.z_out <= s4_z_q[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= in_valid_i;
      // alert samples die here; restart events always pass
      if (ld2) s2_v_q <= s1_v_q && (s1_q.kind || !alert_any);
      // only restarts and completed reports go on past the accumulator
      if (ld3) s3_v_q <= s2_v_q && (s2_restart_q || report);
      if (ld4) s4_v_q <= s3_v_q;
      if (ld_o) out_v_q <= s4_v_q && !s4_restart_q && !suppress;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/asc_axis_scale.sv =====
module asc_axis_scale
  import asc_pkg::*;
(
  input  logic [RAW_W-1:0]          raw_i,
  input  logic [GS_W-1:0]           gravity_step_i,
  output logic                      alert_o,
  output logic signed [SCALE_W-1:0] scaled_o
);

  logic signed [SCALE_W:0] prod;

  assign alert_o = raw_i[ALERT_BIT];

  // low six bits are a two's complement count
  assign prod     = $signed(raw_i[COUNT_W-1:0]) * $signed({1'b0, gravity_step_i});
  assign scaled_o = prod[SCALE_W-1:0];

endmodule

// ===== sv/asc_avg_div.sv =====
module asc_avg_div
  import asc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_REPORT = 1
) (
  input  logic signed [SUM_W-1:0] sum_i,
  output logic signed [SUM_W-1:0] quot_o
);

  localparam logic [RECIP_W-1:0] Recip = RECIP_W'(
    ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_REPORT) - 64'd1) / 64'(SAMPLES_PER_REPORT));

  logic                     neg;
  logic [SUM_W-1:0]         sum_abs;
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [MAG_W-1:0]         q_mag;

  // truncation toward zero: divide the magnitude, then restore the sign
  assign neg     = sum_i[SUM_W-1];
  assign sum_abs = neg ? -sum_i : sum_i;
  assign prod    = sum_abs[MAG_W-1:0] * Recip;
  assign q_mag   = prod[RECIP_SHIFT +: MAG_W];
  assign quot_o  = neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

endmodule

// ===== sv/asc_checker.sv =====
module asc_checker
  import asc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a waiting report is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  // the pipe only backs up behind a stalled, full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // input stall can only start right after an item was taken
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a preceding accept");

endmodule

bind accel_sample_conditioner asc_checker u_asc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o(out_item_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import asc_pkg::*;
();

  // Predictor and checker for the conditioned accelerometer reports.
  class report_scoreboard;
    // Copy of the configuration registers
    int unsigned gstep;
    bit          remap_on;
    logic [MAP_W-1:0] omap;
    bit          swap_on;

    // Copy of the accumulator state
    int          acc_x, acc_y, acc_z;
    int unsigned taken;
    int unsigned drops_left;

    int          per_report;
    int unsigned drop_arm;

    out_item_t   reports_due[$];
    int          errors;

    function new(int spr, int unsigned arm_count);
      per_report = spr;
      drop_arm   = arm_count;
      errors     = 0;
      gstep      = GRAVITY_STEP_RST;
      remap_on   = 1'b0;
      omap       = ORIENTATION_MAP_RST;
      swap_on    = 1'b0;
      acc_x      = 0;
      acc_y      = 0;
      acc_z      = 0;
      taken      = 0;
      drops_left = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_GRAVITY_STEP:    gstep = v[GS_W-1:0];
        CFG_REMAP_ENABLE:    remap_on = v[0];
        CFG_ORIENTATION_MAP: omap = v[MAP_W-1:0];
        CFG_SWAP_XY:         swap_on = v[0];
        default: ;
      endcase
    endfunction

    function int scaled(logic [RAW_W-1:0] raw);
      int c;
      c = int'(raw[COUNT_W-1:0]);
      if (c >= 32) c -= 64;
      return c * int'(gstep);
    endfunction

    function int weight(int unsigned idx);
      logic [1:0] code;
      code = omap[2*idx +: 2];
      if (code == MAP_PLUS) return 1;
      if (code == MAP_MINUS) return -1;
      return 0;  // zero and the unused code
    endfunction

    function int dead_band(int v);
      int pull;
      pull = int'(PULL_STEPS) * int'(gstep);
      if (v > DEAD_ZONE) return v - pull;
      if (v < -DEAD_ZONE) return v + pull;
      return 0;
    endfunction

    // Work out what one accepted item leads to
    function void note_sample(in_item_t it);
      int a[3];
      int m[3];
      int vx, vy, vz, t;
      out_item_t rep;
      if (it.kind) begin
        drops_left = drop_arm;
        return;
      end
      if (it.x_raw[ALERT_BIT] || it.y_raw[ALERT_BIT] || it.z_raw[ALERT_BIT]) return;
      a[0] = scaled(it.x_raw);
      a[1] = scaled(it.y_raw);
      a[2] = scaled(it.z_raw);
      for (int r = 0; r < 3; r++) begin
        if (remap_on)
          m[r] = weight(3*r) * a[0] + weight(3*r + 1) * a[1] + weight(3*r + 2) * a[2];
        else
          m[r] = a[r];
      end
      if (swap_on) begin
        t    = -m[0];
        m[0] = m[1];
        m[1] = t;
      end
      acc_x += m[0];
      acc_y += m[1];
      acc_z += m[2];
      if (taken + 1 < per_report) begin
        taken++;
        return;
      end
      taken = 0;
      vx = dead_band(acc_x / per_report);
      vy = dead_band(acc_y / per_report);
      vz = acc_z / per_report;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      if (drops_left > 0) begin
        drops_left--;
        if (vx == 0 && vy == 0 && vz == 0) return;
      end
      rep.x_out = vx[15:0];
      rep.y_out = vy[15:0];
      rep.z_out = vz[15:0];
      reports_due.push_back(rep);
    endfunction

    task flag_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_report(out_item_t got);
      out_item_t want;
      logic [47:0] g, w;
      string axis;
      axis = "xyz";
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected report %0d %0d %0d",
                                got.x_out, got.y_out, got.z_out));
        return;
      end
      want = reports_due.pop_front();
      g = got;
      w = want;
      for (int i = 0; i < 3; i++) begin
        if (g[47-16*i -: 16] !== w[47-16*i -: 16])
          flag_mismatch($sformatf("%c_out got %0d want %0d", axis[i],
                                  $signed(g[47-16*i -: 16]), $signed(w[47-16*i -: 16])));
      end
    endtask
  endclass

  localparam int          SPR   = 1;
  localparam int unsigned DROPS = 2;
  localparam int          ItemW = $bits(in_item_t);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shared between the stimulus and the receiver process
  bit calm;       // no idling on either side
  bit long_hold;  // request for one long output hold-off

  report_scoreboard sb;

  accel_sample_conditioner #(
    .SAMPLES_PER_REPORT(SPR),
    .DROP_REPORTS      (DROPS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Both channels are sampled at the rising edge, before the block's
  // registers move; inputs only ever change at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_item);
      if (out_valid && !out_stall) sb.check_report(out_item);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else if (long_hold) begin
        // long enough for the whole pipe to fill and back up the input
        out_stall = 1'b1;
        hold      = 79;
        long_hold = 1'b0;
      end else if (calm) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 6) == 0) burst = $urandom_range(1, 13);
      end
    end
  end

  function automatic in_item_t mk(logic k, logic [7:0] x, logic [7:0] y, logic [7:0] z);
    in_item_t it;
    it.kind  = k;
    it.x_raw = x;
    it.y_raw = y;
    it.z_raw = z;
    return it;
  endfunction

  // Mostly clean samples; some restarts, alerts and near-zero samples so
  // that armed reports really get suppressed.
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    int pick;
    it = ItemW'($urandom);
    it.kind = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      it.kind = 1'b1;
    end else if (r < 16) begin
      pick = $urandom_range(0, 2);
      it.x_raw[ALERT_BIT] = (pick == 0) | it.x_raw[ALERT_BIT];
      it.y_raw[ALERT_BIT] = (pick == 1) | it.y_raw[ALERT_BIT];
      it.z_raw[ALERT_BIT] = (pick == 2) | it.z_raw[ALERT_BIT];
    end else if (r < 30) begin
      it.x_raw[5:0] = 6'($signed($urandom_range(0, 4)) - 2);
      it.y_raw[5:0] = 6'($signed($urandom_range(0, 4)) - 2);
      it.z_raw[5:0] = '0;
      it.x_raw[ALERT_BIT] = 1'b0;
      it.y_raw[ALERT_BIT] = 1'b0;
      it.z_raw[ALERT_BIT] = 1'b0;
    end else begin
      it.x_raw[ALERT_BIT] = 1'b0;
      it.y_raw[ALERT_BIT] = 1'b0;
      it.z_raw[ALERT_BIT] = 1'b0;
    end
    return it;
  endfunction

  // Offer one item, with an optional idle burst first; returns once accepted.
  task send_item(in_item_t it);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every due report, then let trailing no-result items drain
  task settle();
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task load_config(logic [7:0] gs, logic rmp, logic [MAP_W-1:0] map, logic sw);
    write_reg(CFG_GRAVITY_STEP, CFG_DATA_W'(gs));
    write_reg(CFG_REMAP_ENABLE, CFG_DATA_W'(rmp));
    write_reg(CFG_ORIENTATION_MAP, map);
    write_reg(CFG_SWAP_XY, CFG_DATA_W'(sw));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task run_phase(int n, bit with_hold);
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == 40) long_hold = 1'b1;
      send_item(random_item());
    end
    end_burst();
    settle();
  endtask

  initial begin
    sb        = new(SPR, DROPS);
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_GRAVITY_STEP;
    cfg_wdata = '0;
    calm      = 1'b0;
    long_hold = 1'b0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, register defaults straight out of reset
    send_item(mk(1'b0, 8'h00, 8'h00, 8'h00));  // zero, not armed: reported
    send_item(mk(1'b0, 8'h1f, 8'h1f, 8'h1f));  // largest count
    send_item(mk(1'b0, 8'h20, 8'h20, 8'h20));  // most negative count
    send_item(mk(1'b0, 8'h3f, 8'h3f, 8'h3f));  // -1: x/y inside dead zone
    send_item(mk(1'b0, 8'h9f, 8'ha0, 8'hbf));  // bit 7 ignored
    send_item(mk(1'b0, 8'h40, 8'h00, 8'h00));  // alert on x
    send_item(mk(1'b0, 8'h00, 8'h7f, 8'h00));  // alert on y
    send_item(mk(1'b0, 8'h00, 8'h00, 8'hc0));  // alert on z
    send_item(mk(1'b0, 8'hff, 8'hff, 8'hff));
    send_item(mk(1'b0, 8'h02, 8'h03, 8'h3d));  // dead zone edges
    send_item(mk(1'b0, 8'h3e, 8'h3d, 8'h00));
    send_item(mk(1'b1, 8'hff, 8'hff, 8'hff));  // restart arms drop counter
    send_item(mk(1'b0, 8'h00, 8'h00, 8'h00));  // suppressed
    send_item(mk(1'b0, 8'h81, 8'h01, 8'h80));  // all zero again: suppressed
    send_item(mk(1'b0, 8'h00, 8'h00, 8'h00));  // counter spent: reported
    send_item(mk(1'b1, 8'h00, 8'h00, 8'h00));
    send_item(mk(1'b0, 8'h1f, 8'h00, 8'h00));  // nonzero report still uses a drop
    send_item(mk(1'b0, 8'h01, 8'h01, 8'h00));  // suppressed
    send_item(mk(1'b0, 8'h00, 8'h00, 8'h00));  // reported
    send_item(mk(1'b1, 8'h55, 8'haa, 8'h7f));
    send_item(mk(1'b0, 8'h40, 8'h40, 8'h40));  // alert leaves the drop count alone
    send_item(mk(1'b0, 8'h00, 8'h00, 8'h00));  // suppressed
    end_burst();
    settle();

    // Extreme gains with remap (including the unused code) and swap
    load_config(8'd255, 1'b1, 18'h2c6e7, 1'b1);
    send_item(mk(1'b0, 8'h1f, 8'h20, 8'h3f));
    send_item(mk(1'b0, 8'h20, 8'h20, 8'h20));
    send_item(mk(1'b0, 8'h1f, 8'h1f, 8'h1f));
    end_burst();
    settle();

    // Random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_config(8'd47, 1'b0, ORIENTATION_MAP_RST, 1'b0);
        1: load_config(8'd255, 1'b1, MAP_W'($urandom), 1'b1);
        2: load_config(8'd0, 1'b1, 18'h3ffff, 1'b0);
        3: load_config(8'd1, 1'b0, ORIENTATION_MAP_RST, 1'b1);
        4: load_config(8'd255, 1'b1, 18'h3ffff, 1'b0);
        5: load_config(8'($urandom), 1'b1, 18'h00000, 1'b1);
        default: load_config(8'($urandom), 1'($urandom), MAP_W'($urandom), 1'($urandom));
      endcase
      calm = (p == 7);
      run_phase(200, p == 1 || p == 5);
    end

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/asc_pkg.sv
sv/asc_axis_scale.sv
sv/asc_avg_div.sv
sv/accel_sample_conditioner.sv
sv/asc_checker.sv
tb/tb_top.sv
